>>> src/ile_pkg.sv
package ile_pkg;

    localparam int ILE_CAPACITY = 16;

    localparam int CMD_W = 3;
    localparam int IDX_W = 8;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int IN_W  = 48;

    localparam logic [CMD_W-1:0] CMD_GET      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL      = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
    localparam logic [ST_W-1:0] ST_BADIDX = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    localparam logic [VAL_W-1:0] NEG_ONE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_GET  = 2'd1,
        OP_INS  = 2'd2,
        OP_DEL  = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic shift;
        logic publish;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic shift_done;
        logic out_busy;
    } ctrl_stat_t;

endpackage

>>> src/ile_datapath.sv
module ile_datapath
    import ile_pkg::*;
#(
    parameter int CAPACITY = ILE_CAPACITY,
    localparam int LEN_W  = $clog2(CAPACITY + 1),
    localparam int ADDR_W = $clog2(CAPACITY)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output ctrl_stat_t        stat,
    input  logic [CMD_W-1:0]  in_cmd,
    input  logic [IDX_W-1:0]  in_index,
    input  logic [VAL_W-1:0]  in_value,
    input  logic              m_tready,
    output logic              out_valid,
    output logic [VAL_W-1:0]  read_value,
    output logic [ST_W-1:0]   status,
    output logic [LEN_W-1:0]  length
);

    localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAPACITY);

    logic [VAL_W-1:0] mem [CAPACITY];

    logic [CMD_W-1:0]  cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [VAL_W-1:0]  val_reg;
    op_t               op_reg, op_next;
    logic [ST_W-1:0]   st_reg, st_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic              wr_valid_reg, wr_valid_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [VAL_W-1:0]  rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_rv_reg;
    logic [ST_W-1:0]   out_st_reg;
    logic [LEN_W-1:0]  out_len_reg;

    op_t               dec_op;
    logic [ST_W-1:0]   dec_st;
    logic [ADDR_W-1:0] dec_pos;
    logic              idx_lt_cnt;
    logic              idx_le_cnt;
    logic              is_full;
    logic [LEN_W-1:0]  ptr_ext;
    logic              more;
    logic              shift_done;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    assign idx_lt_cnt = {{LEN_W{1'b0}}, idx_reg} <  {{IDX_W{1'b0}}, count_reg};
    assign idx_le_cnt = {{LEN_W{1'b0}}, idx_reg} <= {{IDX_W{1'b0}}, count_reg};
    assign is_full    = (count_reg == CAP_L);

    always_comb
    begin
        dec_op  = OP_NONE;
        dec_st  = ST_DONE;
        dec_pos = '0;
        case (cmd_reg)
            CMD_GET:
            begin
                if (idx_lt_cnt) dec_op = OP_GET;
                else            dec_st = ST_BADIDX;
                dec_pos = idx_reg[ADDR_W-1:0];
            end
            CMD_INS_HEAD:
            begin
                if (is_full) dec_st = ST_FULL;
                else         dec_op = OP_INS;
            end
            CMD_INS_TAIL:
            begin
                if (is_full) dec_st = ST_FULL;
                else         dec_op = OP_INS;
                dec_pos = count_reg[ADDR_W-1:0];
            end
            CMD_INS_AT:
            begin
                if (!idx_le_cnt)  dec_st = ST_BADIDX;
                else if (is_full) dec_st = ST_FULL;
                else              dec_op = OP_INS;
                dec_pos = idx_reg[ADDR_W-1:0];
            end
            CMD_DEL:
            begin
                if (idx_lt_cnt) dec_op = OP_DEL;
                else            dec_st = ST_BADIDX;
                dec_pos = idx_reg[ADDR_W-1:0];
            end
            default:
            begin
                dec_op = OP_NONE;
            end
        endcase
    end

    // insert walks down from the tail, delete walks up from the hole
    assign ptr_ext = LEN_W'(ptr_reg);
    assign more = (op_reg == OP_INS) ? (ptr_reg > pos_reg)
                : (op_reg == OP_DEL) ? (LEN_W'(ptr_ext + LEN_W'(1)) < count_reg)
                : 1'b0;
    assign shift_done = !more && !wr_valid_reg;

    always_comb
    begin
        op_next        = op_reg;
        st_next        = st_reg;
        pos_next       = pos_reg;
        ptr_next       = ptr_reg;
        wr_addr_next   = wr_addr_reg;
        wr_valid_next  = wr_valid_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_re         = 1'b0;
        mem_raddr      = dec_pos;
        mem_we         = 1'b0;
        mem_waddr      = wr_valid_reg ? wr_addr_reg : pos_reg;
        mem_wdata      = wr_valid_reg ? rd_data_reg : val_reg;

        if (cmd.decode)
        begin
            op_next       = dec_op;
            st_next       = dec_st;
            pos_next      = dec_pos;
            ptr_next      = (dec_op == OP_INS) ? count_reg[ADDR_W-1:0] : dec_pos;
            wr_valid_next = 1'b0;
            mem_re        = (dec_op == OP_GET);
        end

        if (cmd.shift)
        begin
            mem_raddr     = (op_reg == OP_INS) ? ADDR_W'(ptr_reg - ADDR_W'(1))
                                               : ADDR_W'(ptr_reg + ADDR_W'(1));
            mem_re        = more;
            wr_valid_next = more;
            wr_addr_next  = ptr_reg;
            if (more)
                ptr_next = mem_raddr;
            mem_we = wr_valid_reg || (shift_done && op_reg == OP_INS);
            if (shift_done)
            begin
                if (op_reg == OP_INS)
                    count_next = LEN_W'(count_reg + LEN_W'(1));
                else if (op_reg == OP_DEL)
                    count_next = LEN_W'(count_reg - LEN_W'(1));
            end
        end

        if (cmd.publish)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_NONE;
        end
        else
        begin
            count_reg     <= count_next;
            wr_valid_reg  <= wr_valid_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= in_cmd;
            idx_reg <= in_index;
            val_reg <= in_value;
        end
        st_reg      <= st_next;
        pos_reg     <= pos_next;
        ptr_reg     <= ptr_next;
        wr_addr_reg <= wr_addr_next;
        if (cmd.publish)
        begin
            out_rv_reg  <= (op_reg == OP_GET) ? rd_data_reg : NEG_ONE;
            out_st_reg  <= st_reg;
            out_len_reg <= count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    assign stat.op         = dec_op;
    assign stat.shift_done = shift_done;
    assign stat.out_busy   = out_valid_reg && !m_tready;

    assign out_valid  = out_valid_reg;
    assign read_value = out_rv_reg;
    assign status     = out_st_reg;
    assign length     = out_len_reg;

endmodule

>>> src/ile_ctrl.sv
module ile_ctrl
    import ile_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (stat.op == OP_INS || stat.op == OP_DEL)
                    state_next = S_SHIFT;
                else
                    state_next = S_FINISH;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!stat.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> src/indexed_list_engine_top.sv
// Channel   Dir  Width  Contents
// s_axis    in   48     command beat: cmd, index, value
// m_axis    out  40     result beat: read_value, status, length
//
// A get, a rejected command or an unused code passes through accept, decode and
// finish. Its result beat is registered by the finish step.
// An insert or delete moves one list entry per cycle through the single-write-port
// list memory, in a shift step between decode and finish that lasts until the
// last move is written.
// One command is in flight at a time; the next is accepted while the previous
// result still waits in the output register. rst_n clears the length and all
// handshake state; list contents are not cleared. A stalled m_tready holds
// the result and stalls only the finish step of the next command.
module indexed_list_engine_top
    import ile_pkg::*;
#(
    parameter int CAPACITY = ILE_CAPACITY,
    localparam int LEN_W = $clog2(CAPACITY + 1),
    localparam int OUT_W = ((VAL_W + ST_W + LEN_W + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // cmd[2:0], index[10:3], value[42:11], zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // read_value[31:0], status[33:32], length[38:34], pad
);

    ctrl_cmd_t        cmd;
    ctrl_stat_t       stat;
    logic [VAL_W-1:0] read_value;
    logic [ST_W-1:0]  status;
    logic [LEN_W-1:0] length;

    ile_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // unpack the command beat straight into the datapath capture registers
    ile_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_cmd     (s_tdata[CMD_W-1:0]),
        .in_index   (s_tdata[CMD_W+IDX_W-1:CMD_W]),
        .in_value   (s_tdata[CMD_W+IDX_W+VAL_W-1:CMD_W+IDX_W]),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .read_value (read_value),
        .status     (status),
        .length     (length)
    );

    // pack the result beat, zero-filled to whole bytes
    assign m_tdata = OUT_W'({length, status, read_value});

endmodule

>>> test/tb_top.sv
// Testbench for indexed_list_engine_top.
// Drives list commands on the s_ stream, mirrors every accepted command in a
// shadow list held here, and compares each m_ stream beat field by field with
// the oldest outstanding prediction.
module tb_top;
    import ile_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_W = $clog2(ILE_CAPACITY + 1);
    localparam int OUT_W = ((VAL_W + ST_W + LEN_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 894;
    localparam int DRAIN_CYCLES = ILE_CAPACITY + 8;

    // One result beat split into its fields.
    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] length;
    } list_result_t;

    // One row of the directed stimulus table. A row with reps > 1 repeats the
    // command with value + k. Rows with has_want carry a hand-typed result;
    // the rest are checked against the shadow list.
    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
        int               reps;
        bit               has_want;
        list_result_t     want;
    } cmd_row_t;

    // Clock, reset and stream signals; every block input starts at a known value.
    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;   // cmd[2:0], index[10:3], value[42:11], zero pad
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;         // read_value[31:0], status[33:32], length[38:34], pad

    // Shadow copy of the list contents and its length.
    logic [VAL_W-1:0] shadow_vals [ILE_CAPACITY];
    int unsigned      shadow_len;

    // Results still owed by the block, oldest first.
    list_result_t     owed_results[$];
    cmd_row_t         cmd_table[$];

    int  mismatches;
    int  cmds_sent;
    int  results_seen;
    int  full_rejects;
    int  badidx_rejects;
    int  unused_codes;
    int  peak_len;
    int  burst_left;
    bit  growing;

    // Receiver pacing state.
    bit  hold_req;
    int  hold_left;
    int  rx_mode;
    int  rx_phase;

    indexed_list_engine_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Open a hole at pos and drop v into it, shifting the tail up one place.
    // The index check comes first, then the capacity check.
    function automatic logic [ST_W-1:0] shadow_insert(int unsigned pos, logic [VAL_W-1:0] v);
        int unsigned k;
        if (pos > shadow_len)
            return ST_BADIDX;
        if (shadow_len >= ILE_CAPACITY)
            return ST_FULL;
        for (k = shadow_len; k > pos; k--)
            shadow_vals[k] = shadow_vals[k-1];
        shadow_vals[pos] = v;
        shadow_len++;
        return ST_DONE;
    endfunction

    // Apply one command to the shadow list and return the result it owes.
    function automatic list_result_t apply_list_cmd(logic [CMD_W-1:0] cmd,
                                                   logic [IDX_W-1:0] idx,
                                                   logic [VAL_W-1:0] val);
        list_result_t r;
        int unsigned  k;
        r.read_value = NEG_ONE;
        r.status     = ST_DONE;
        case (cmd)
            CMD_GET:
            begin
                if (idx < shadow_len)
                    r.read_value = shadow_vals[idx];
                else
                    r.status = ST_BADIDX;
            end
            CMD_INS_HEAD: r.status = shadow_insert(0, val);
            CMD_INS_TAIL: r.status = shadow_insert(shadow_len, val);
            CMD_INS_AT:   r.status = shadow_insert(idx, val);
            CMD_DEL:
            begin
                if (idx < shadow_len)
                begin
                    for (k = idx; k + 1 < shadow_len; k++)
                        shadow_vals[k] = shadow_vals[k+1];
                    shadow_len--;
                end
                else
                    r.status = ST_BADIDX;
            end
            default: ;
        endcase
        r.length = shadow_len[LEN_W-1:0];
        return r;
    endfunction

    task automatic add_row(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                           logic [VAL_W-1:0] val, int reps, bit has_want,
                           logic [VAL_W-1:0] rv, logic [ST_W-1:0] st, int len);
        cmd_row_t row;
        row.cmd             = cmd;
        row.index           = idx;
        row.value           = val;
        row.reps            = reps;
        row.has_want        = has_want;
        row.want.read_value = rv;
        row.want.status     = st;
        row.want.length     = LEN_W'(len);
        cmd_table.push_back(row);
    endtask

    // Offer one command beat, hold it until accepted, then log what it owes.
    // valid stays high on return so back-to-back beats need no extra edge.
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                            logic [VAL_W-1:0] val, bit has_want, list_result_t want);
        list_result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - CMD_W - IDX_W - VAL_W){1'b0}}, val, idx, cmd};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        r = apply_list_cmd(cmd, idx, val);
        owed_results.push_back(has_want ? want : r);
        cmds_sent++;
        if (r.status == ST_FULL)
            full_rejects++;
        if (r.status == ST_BADIDX)
            badidx_rejects++;
        if (cmd > CMD_DEL)
            unused_codes++;
        if (shadow_len > peak_len)
            peak_len = shadow_len;
    endtask

    // Sender pacing: bursts of random length, random gaps between them, and
    // now and then a long burst with no gap at all.
    task automatic pace_sender();
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (owed_results.size() != 0);
    endtask

    // Pick a random command. Most indexes land inside the list (or exactly at
    // its end for an insert) so the shift paths get exercised; the rest span
    // the full 8-bit range. growing tips the mix toward inserts so the list
    // keeps reaching full, and its opposite drains the list back to empty.
    task automatic pick_cmd(output logic [CMD_W-1:0] cmd, output logic [IDX_W-1:0] idx,
                            output logic [VAL_W-1:0] val);
        int unsigned roll;
        int unsigned len;
        int unsigned ins_top;
        len     = shadow_len;
        roll    = $urandom_range(0, 99);
        ins_top = growing ? 75 : 45;
        idx     = IDX_W'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = 32'h0000_0000;
            3:       val = 32'hFFFF_FFFF;
            default: val = $urandom;
        endcase
        if (roll < 3)
            cmd = CMD_W'($urandom_range(5, 7));
        else if (roll < 25)
        begin
            cmd = CMD_GET;
            if (len > 0 && $urandom_range(0, 9) < 8)
                idx = IDX_W'($urandom_range(0, len - 1));
        end
        else if (roll < ins_top)
        begin
            case ($urandom_range(0, 2))
                0:       cmd = CMD_INS_HEAD;
                1:       cmd = CMD_INS_TAIL;
                default: cmd = CMD_INS_AT;
            endcase
            case ($urandom_range(0, 9))
                8:       idx = IDX_W'(len);
                9:       ;
                default: idx = IDX_W'($urandom_range(0, len));
            endcase
        end
        else
        begin
            cmd = CMD_DEL;
            if (len > 0 && $urandom_range(0, 9) < 9)
                idx = IDX_W'($urandom_range(0, len - 1));
        end
    endtask

    // Receiver: stall on a pattern of its own that picks a new mode at random
    // whenever its phase count runs out. On request, hold off for a long stretch
    // so the engine backs up and stalls its input.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = 399;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_phase == 0)
            begin
                rx_mode  = $urandom_range(0, 3);
                rx_phase = $urandom_range(20, 120);
            end
            else
                rx_phase--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 6) != 0);
            endcase
        end
    end

    // Result checker: pop the oldest owed result on every accepted beat and
    // compare field by field. Report the first ten failures, count the rest.
    always @(posedge clk)
    begin
        list_result_t want;
        list_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.read_value = m_tdata[VAL_W-1:0];
            got.status     = m_tdata[VAL_W +: ST_W];
            got.length     = m_tdata[VAL_W + ST_W +: LEN_W];
            results_seen++;
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected beat: value %h status %0d length %0d",
                             got.read_value, got.status, got.length);
            end
            else
            begin
                want = owed_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: result %0d: want %h/%0d/%0d, got %h/%0d/%0d",
                                 results_seen, want.read_value, want.status, want.length,
                                 got.read_value, got.status, got.length);
                end
            end
        end
    end

    // Hard limit on the run; the slowest legal run is well under a tenth of it.
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        cmd_row_t         row;
        list_result_t     none;
        int               k;

        none       = '0;
        shadow_len = 0;
        burst_left = $urandom_range(1, 16);
        growing    = 1'b1;
        hold_req   = 1'b0;
        hold_left  = 0;
        rx_mode    = 0;
        rx_phase   = 0;

        // Directed table. Hand-typed rows cover the empty list, unused codes,
        // the extreme values, the full list and out-of-range indexes.
        add_row(CMD_GET,      8'd0,   32'h0000_0000, 1, 1, NEG_ONE, ST_BADIDX, 0);
        add_row(CMD_DEL,      8'd0,   32'h0000_0000, 1, 1, NEG_ONE, ST_BADIDX, 0);
        add_row(CMD_INS_AT,   8'd1,   32'h0000_0005, 1, 1, NEG_ONE, ST_BADIDX, 0);
        add_row(CMD_INS_AT,   8'd255, 32'hFFFF_FFFF, 1, 1, NEG_ONE, ST_BADIDX, 0);
        add_row(3'd5,         8'd255, 32'hFFFF_FFFF, 1, 1, NEG_ONE, ST_DONE,   0);
        add_row(3'd6,         8'hAA,  32'h5555_5555, 1, 1, NEG_ONE, ST_DONE,   0);
        add_row(3'd7,         8'd0,   32'h0000_0000, 1, 1, NEG_ONE, ST_DONE,   0);
        add_row(CMD_INS_HEAD, 8'd0,   32'h7FFF_FFFF, 1, 1, NEG_ONE, ST_DONE,   1);
        add_row(CMD_INS_TAIL, 8'd0,   32'h8000_0000, 1, 1, NEG_ONE, ST_DONE,   2);
        add_row(CMD_GET,      8'd0,   32'h0000_0000, 1, 1, 32'h7FFF_FFFF, ST_DONE, 2);
        add_row(CMD_GET,      8'd1,   32'h0000_0000, 1, 1, 32'h8000_0000, ST_DONE, 2);
        add_row(CMD_GET,      8'd2,   32'h0000_0000, 1, 1, NEG_ONE, ST_BADIDX, 2);
        // Insert at an index equal to the length appends.
        add_row(CMD_INS_AT,   8'd2,   32'h0000_0000, 1, 1, NEG_ONE, ST_DONE,   3);
        add_row(CMD_INS_AT,   8'd1,   32'h1234_5678, 1, 0, '0, '0, 0);
        add_row(CMD_GET,      8'd1,   32'h0000_0000, 1, 0, '0, '0, 0);
        add_row(CMD_DEL,      8'd0,   32'h0000_0000, 1, 0, '0, '0, 0);
        add_row(CMD_GET,      8'd0,   32'h0000_0000, 1, 0, '0, '0, 0);
        // Fill to capacity, then every insert flavor is turned away as full,
        // except an index past the length, which is checked first.
        add_row(CMD_INS_TAIL, 8'd0,   32'hA000_0000, ILE_CAPACITY - 3, 0, '0, '0, 0);
        add_row(CMD_INS_HEAD, 8'd0,   32'hDEAD_BEEF, 1, 1, NEG_ONE, ST_FULL,   ILE_CAPACITY);
        add_row(CMD_INS_AT,   8'(ILE_CAPACITY),     32'h0000_0001, 1, 1,
                NEG_ONE, ST_FULL, ILE_CAPACITY);
        add_row(CMD_INS_AT,   8'(ILE_CAPACITY + 1), 32'h0000_0002, 1, 1,
                NEG_ONE, ST_BADIDX, ILE_CAPACITY);
        add_row(CMD_INS_TAIL, 8'd0,   32'h0000_0003, 1, 1, NEG_ONE, ST_FULL,   ILE_CAPACITY);
        add_row(CMD_GET,      8'(ILE_CAPACITY - 1), 32'h0, 1, 0, '0, '0, 0);
        add_row(CMD_GET,      8'(ILE_CAPACITY),     32'h0, 1, 1,
                NEG_ONE, ST_BADIDX, ILE_CAPACITY);
        add_row(CMD_DEL,      8'(ILE_CAPACITY - 1), 32'h0, 1, 0, '0, '0, 0);
        add_row(CMD_DEL,      8'd0,   32'h0000_0000, 1, 0, '0, '0, 0);
        add_row(CMD_DEL,      8'd200, 32'h0000_0000, 1, 1, NEG_ONE, ST_BADIDX, ILE_CAPACITY - 2);
        add_row(CMD_INS_AT,   8'd7,   32'hCAFE_F00D, 1, 0, '0, '0, 0);
        // Empty the list from the head, then read past the end once more.
        add_row(CMD_DEL,      8'd0,   32'h0000_0000, ILE_CAPACITY - 1, 0, '0, '0, 0);
        add_row(CMD_GET,      8'd0,   32'h0000_0000, 1, 1, NEG_ONE, ST_BADIDX, 0);

        // Hold reset low from the start, then release it for good.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        foreach (cmd_table[r])
        begin
            row = cmd_table[r];
            for (k = 0; k < row.reps; k++)
            begin
                send_cmd(row.cmd, row.index, row.value + VAL_W'(k), row.has_want, row.want);
                pace_sender();
            end
        end

        // Pause the sender until the directed results are all back.
        drain_results();

        // Random part, flipping between growing and shrinking the list.
        k = $urandom_range(30, 70);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (--k == 0)
            begin
                growing = !growing;
                k       = $urandom_range(30, 70);
            end
            // Stall the receiver for a long stretch while a gapless burst
            // keeps offering, so the engine fills up and backs off s_tready.
            if (n == 300)
            begin
                hold_req   = 1'b1;
                burst_left = 80;
            end
            // Pause the sender until every owed result has come back.
            if (n == 600)
                drain_results();
            pick_cmd(cmd, idx, val);
            send_cmd(cmd, idx, val, 1'b0, none);
            pace_sender();
        end

        // Let the tail drain, then give the engine its worst-case latency
        // to show any stray beat.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d commands, %0d results, peak length %0d of %0d",
                 cmds_sent, results_seen, peak_len, ILE_CAPACITY);
        $display("tb: %0d full rejects, %0d bad-index rejects, %0d unused codes, %0d mismatches",
                 full_rejects, badidx_rejects, unused_codes, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
